/* design/assert_macros.svh */
// Assertion macros used by the path follower.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* design/wpf_pkg.sv */
package wpf_pkg;

    localparam int COORD_BITS = 24;
    localparam int MAG_BITS = COORD_BITS + 1;
    localparam int SQ_BITS = 2 * MAG_BITS;
    localparam int DIST_BITS = SQ_BITS + 2;
    localparam int COUNT_BITS = 9;
    localparam int CFG_BITS = 32;
    localparam int CFG_INDEX_BITS = 2;
    localparam int MAX_WAYPOINTS_DEFAULT = 256;

    localparam logic [CFG_BITS-1:0] RESET_REACH = 32'd25600;
    localparam logic [CFG_BITS-1:0] RESET_LOOP = 32'd2304;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_REACH = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOOP = 2'd1;

    localparam logic [2:0] ACT_CLEAR = 3'd0;
    localparam logic [2:0] ACT_APPEND = 3'd1;
    localparam logic [2:0] ACT_STEP = 3'd2;
    localparam logic [2:0] ACT_QUERY = 3'd3;
    localparam logic [2:0] ACT_REVERSE = 3'd4;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_REVERSED = 2'd2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } wp_t;

    typedef struct packed {
        logic [2:0] action;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
    } cmd_t;

    typedef struct packed {
        logic found;
        logic signed [COORD_BITS-1:0] way_x;
        logic signed [COORD_BITS-1:0] way_y;
        logic signed [COORD_BITS-1:0] way_z;
        logic [COUNT_BITS-1:0] stored_count;
        logic [1:0] status;
    } rsp_t;

    typedef struct packed {
        logic valid;
        logic [DIST_BITS-1:0] dsq;
        wp_t way;
    } dist_res_t;

    function automatic logic [MAG_BITS-1:0] abs_diff(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic [COORD_BITS:0] d;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        return d[COORD_BITS] ? MAG_BITS'(-d) : MAG_BITS'(d);
    endfunction

endpackage

/* design/wpf_ram.sv */
module wpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* design/wpf_dist.sv */
module wpf_dist #(
    parameter int TAG_BITS = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  wpf_pkg::wp_t              pos,
    input  wpf_pkg::wp_t              way,
    input  logic [TAG_BITS-1:0]       tag_in,
    output wpf_pkg::dist_res_t        res,
    output logic [TAG_BITS-1:0]       tag_out,
    output logic                      busy
);

    logic                         v1_reg;
    logic [wpf_pkg::MAG_BITS-1:0] mag_x_reg, mag_y_reg, mag_z_reg;
    logic [wpf_pkg::MAG_BITS-1:0] mag_x_next, mag_y_next, mag_z_next;
    wpf_pkg::wp_t                 way1_reg;
    logic [TAG_BITS-1:0]          tag1_reg;

    logic                         v2_reg;
    logic [wpf_pkg::SQ_BITS-1:0]  sq_x_reg, sq_y_reg, sq_z_reg;
    logic [wpf_pkg::SQ_BITS-1:0]  sq_x_next, sq_y_next, sq_z_next;
    wpf_pkg::wp_t                 way2_reg;
    logic [TAG_BITS-1:0]          tag2_reg;

    logic                         v3_reg;
    logic [wpf_pkg::DIST_BITS-1:0] dist_reg, dist_next;
    wpf_pkg::wp_t                 way3_reg;
    logic [TAG_BITS-1:0]          tag3_reg;

    always_comb
    begin
        mag_x_next = wpf_pkg::abs_diff(pos.x, way.x);
        mag_y_next = wpf_pkg::abs_diff(pos.y, way.y);
        mag_z_next = wpf_pkg::abs_diff(pos.z, way.z);
        sq_x_next = wpf_pkg::SQ_BITS'(mag_x_reg) * wpf_pkg::SQ_BITS'(mag_x_reg);
        sq_y_next = wpf_pkg::SQ_BITS'(mag_y_reg) * wpf_pkg::SQ_BITS'(mag_y_reg);
        sq_z_next = wpf_pkg::SQ_BITS'(mag_z_reg) * wpf_pkg::SQ_BITS'(mag_z_reg);
        dist_next = wpf_pkg::DIST_BITS'(sq_x_reg) + wpf_pkg::DIST_BITS'(sq_y_reg)
                  + wpf_pkg::DIST_BITS'(sq_z_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_x_reg <= mag_x_next;
        mag_y_reg <= mag_y_next;
        mag_z_reg <= mag_z_next;
        way1_reg <= way;
        tag1_reg <= tag_in;
        sq_x_reg <= sq_x_next;
        sq_y_reg <= sq_y_next;
        sq_z_reg <= sq_z_next;
        way2_reg <= way1_reg;
        tag2_reg <= tag1_reg;
        dist_reg <= dist_next;
        way3_reg <= way2_reg;
        tag3_reg <= tag2_reg;
    end

    assign res.valid = v3_reg;
    assign res.dsq = dist_reg;
    assign res.way = way3_reg;
    assign tag_out = tag3_reg;
    assign busy = v1_reg | v2_reg | v3_reg;

endmodule

/* design/waypoint_path_follower.sv */
// Waypoints live in one RAM with a single read port. A nearest search streams
// every stored waypoint, one per cycle in logical order, through a three-stage
// squared-distance pipeline behind the RAM's registered read; a query, or a
// step that has to pick a target, runs such a search over the whole table. A
// step that already has a target does one to three single reads. Clear, append
// and reverse read nothing. The result sits in an output register, so the next
// item is taken while it waits. The store needs no clearing pass after reset,
// since only entries below the stored count are ever read.
module waypoint_path_follower #(
    parameter int MAX_WAYPOINTS = wpf_pkg::MAX_WAYPOINTS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cmd_valid,
    output logic                               cmd_stall,
    input  wpf_pkg::cmd_t                      cmd,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output wpf_pkg::rsp_t                      rsp,
    input  logic                               cfg_we,
    input  logic [wpf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [wpf_pkg::CFG_BITS-1:0]       cfg_data
);

    `include "assert_macros.svh"

    localparam int IDX_BITS = $clog2(MAX_WAYPOINTS);
    localparam int CNT_BITS = $clog2(MAX_WAYPOINTS + 1);
    localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_WAYPOINTS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NEAR = 3'd1;
    localparam logic [2:0] S_TGT = 3'd2;
    localparam logic [2:0] S_START = 3'd3;
    localparam logic [2:0] S_FETCH = 3'd4;
    localparam logic [2:0] S_OUT = 3'd5;

    logic [2:0]                    state_reg, state_next;
    logic [CNT_BITS-1:0]           total_reg, total_next;
    logic [IDX_BITS-1:0]           target_reg, target_next;
    logic                          tvalid_reg, tvalid_next;
    logic                          rev_reg, rev_next;
    logic [wpf_pkg::CFG_BITS-1:0]  reach_reg, reach_next;
    logic [wpf_pkg::CFG_BITS-1:0]  loop_reg, loop_next;
    logic [2:0]                    act_reg, act_next;
    wpf_pkg::wp_t                  pos_reg, pos_next;
    logic [1:0]                    status_reg, status_next;
    logic                          found_reg, found_next;
    logic                          iss_active_reg, iss_active_next;
    logic [IDX_BITS-1:0]           iss_addr_reg, iss_addr_next;
    logic [CNT_BITS-1:0]           iss_left_reg, iss_left_next;
    logic                          iss_dir_reg, iss_dir_next;
    logic                          rd_vld_reg, rd_vld_next;
    logic [IDX_BITS-1:0]           rd_idx_reg, rd_idx_next;
    logic                          best_have_reg, best_have_next;
    logic [wpf_pkg::DIST_BITS-1:0] best_dist_reg, best_dist_next;
    logic [IDX_BITS-1:0]           best_idx_reg, best_idx_next;
    wpf_pkg::wp_t                  best_way_reg, best_way_next;
    logic                          rsp_valid_reg, rsp_valid_next;
    wpf_pkg::rsp_t                 rsp_reg, rsp_next;

    logic                          ram_we;
    wpf_pkg::wp_t                  ram_wr_data;
    logic [$bits(wpf_pkg::wp_t)-1:0] ram_rd_data;
    wpf_pkg::dist_res_t            dres;
    logic [IDX_BITS-1:0]           dres_idx;
    logic                          dist_busy;

    logic                          ld_en;
    logic [IDX_BITS-1:0]           ld_addr;
    logic [CNT_BITS-1:0]           ld_cnt;
    logic                          ld_dir;

    logic                          done;
    logic [IDX_BITS-1:0]           last_idx;
    logic                          at_end;
    logic                          reached;
    logic                          new_rev;

    assign done = !iss_active_reg && !rd_vld_reg && !dist_busy;
    assign last_idx = IDX_BITS'(total_reg - CNT_BITS'(1));
    assign at_end = rev_reg ? (target_reg == '0) : (target_reg == last_idx);
    assign reached = best_dist_reg < wpf_pkg::DIST_BITS'(reach_reg);
    assign new_rev = (best_dist_reg < wpf_pkg::DIST_BITS'(loop_reg)) ? rev_reg : !rev_reg;
    assign ram_wr_data = '{x: cmd.pos_x, y: cmd.pos_y, z: cmd.pos_z};

    wpf_ram #(
        .WIDTH ($bits(wpf_pkg::wp_t)),
        .DEPTH (MAX_WAYPOINTS)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (total_reg[IDX_BITS-1:0]),
        .wr_data (ram_wr_data),
        .re      (iss_active_reg),
        .rd_addr (iss_addr_reg),
        .rd_data (ram_rd_data)
    );

    wpf_dist #(
        .TAG_BITS (IDX_BITS)
    ) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rd_vld_reg),
        .pos      (pos_reg),
        .way      (wpf_pkg::wp_t'(ram_rd_data)),
        .tag_in   (rd_idx_reg),
        .res      (dres),
        .tag_out  (dres_idx),
        .busy     (dist_busy)
    );

    always_comb
    begin
        state_next = state_reg;
        total_next = total_reg;
        target_next = target_reg;
        tvalid_next = tvalid_reg;
        rev_next = rev_reg;
        reach_next = reach_reg;
        loop_next = loop_reg;
        act_next = act_reg;
        pos_next = pos_reg;
        status_next = status_reg;
        found_next = found_reg;
        iss_active_next = iss_active_reg;
        iss_addr_next = iss_addr_reg;
        iss_left_next = iss_left_reg;
        iss_dir_next = iss_dir_reg;
        best_have_next = best_have_reg;
        best_dist_next = best_dist_reg;
        best_idx_next = best_idx_reg;
        best_way_next = best_way_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next = rsp_reg;
        ram_we = 1'b0;
        ld_en = 1'b0;
        ld_addr = '0;
        ld_cnt = '0;
        ld_dir = 1'b0;

        rd_vld_next = iss_active_reg;
        rd_idx_next = iss_addr_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                wpf_pkg::CFG_REACH: reach_next = cfg_data;
                wpf_pkg::CFG_LOOP:  loop_next = cfg_data;
                default: ;
            endcase
        end

        if (iss_active_reg)
        begin
            iss_addr_next = iss_dir_reg ? iss_addr_reg - 1'b1 : iss_addr_reg + 1'b1;
            iss_left_next = iss_left_reg - CNT_BITS'(1);
            if (iss_left_reg == CNT_BITS'(1))
            begin
                iss_active_next = 1'b0;
            end
        end

        if (dres.valid && (!best_have_reg || dres.dsq < best_dist_reg))
        begin
            best_have_next = 1'b1;
            best_dist_next = dres.dsq;
            best_idx_next = dres_idx;
            best_way_next = dres.way;
        end

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    act_next = cmd.action;
                    pos_next = ram_wr_data;
                    status_next = wpf_pkg::ST_OK;
                    found_next = 1'b0;
                    state_next = S_OUT;
                    case (cmd.action)
                        wpf_pkg::ACT_CLEAR:
                        begin
                            total_next = '0;
                            target_next = '0;
                            tvalid_next = 1'b0;
                            rev_next = 1'b0;
                        end
                        wpf_pkg::ACT_APPEND:
                        begin
                            if (rev_reg)
                            begin
                                status_next = wpf_pkg::ST_REVERSED;
                            end
                            else if (total_reg >= CNT_MAX)
                            begin
                                status_next = wpf_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we = 1'b1;
                                if (total_reg == '0)
                                begin
                                    target_next = '0;
                                    tvalid_next = 1'b1;
                                end
                                total_next = total_reg + CNT_BITS'(1);
                            end
                        end
                        wpf_pkg::ACT_STEP:
                        begin
                            if (total_reg != '0)
                            begin
                                found_next = 1'b1;
                                ld_en = 1'b1;
                                if (!tvalid_reg || CNT_BITS'(target_reg) >= total_reg)
                                begin
                                    ld_addr = rev_reg ? last_idx : '0;
                                    ld_cnt = total_reg;
                                    ld_dir = rev_reg;
                                    state_next = S_NEAR;
                                end
                                else
                                begin
                                    ld_addr = target_reg;
                                    ld_cnt = CNT_BITS'(1);
                                    state_next = S_TGT;
                                end
                            end
                        end
                        wpf_pkg::ACT_QUERY:
                        begin
                            if (total_reg != '0)
                            begin
                                found_next = 1'b1;
                                ld_en = 1'b1;
                                ld_addr = rev_reg ? last_idx : '0;
                                ld_cnt = total_reg;
                                ld_dir = rev_reg;
                                state_next = S_NEAR;
                            end
                        end
                        wpf_pkg::ACT_REVERSE:
                        begin
                            rev_next = !rev_reg;
                        end
                        default: ;
                    endcase
                end
            end
            S_NEAR:
            begin
                if (done)
                begin
                    if (act_reg == wpf_pkg::ACT_STEP)
                    begin
                        target_next = best_idx_reg;
                        tvalid_next = 1'b1;
                    end
                    state_next = S_OUT;
                end
            end
            S_TGT:
            begin
                if (done)
                begin
                    if (reached && !at_end)
                    begin
                        target_next = rev_reg ? target_reg - 1'b1 : target_reg + 1'b1;
                        ld_en = 1'b1;
                        ld_addr = target_next;
                        ld_cnt = CNT_BITS'(1);
                        state_next = S_FETCH;
                    end
                    else if (reached)
                    begin
                        ld_en = 1'b1;
                        ld_addr = rev_reg ? last_idx : '0;
                        ld_cnt = CNT_BITS'(1);
                        state_next = S_START;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_START:
            begin
                if (done)
                begin
                    rev_next = new_rev;
                    target_next = new_rev ? last_idx : '0;
                    ld_en = 1'b1;
                    ld_addr = target_next;
                    ld_cnt = CNT_BITS'(1);
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                if (done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.found = found_reg;
                    rsp_next.way_x = found_reg ? best_way_reg.x : '0;
                    rsp_next.way_y = found_reg ? best_way_reg.y : '0;
                    rsp_next.way_z = found_reg ? best_way_reg.z : '0;
                    rsp_next.stored_count = wpf_pkg::COUNT_BITS'(total_reg);
                    rsp_next.status = status_reg;
                    rsp_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (ld_en)
        begin
            iss_active_next = 1'b1;
            iss_addr_next = ld_addr;
            iss_left_next = ld_cnt;
            iss_dir_next = ld_dir;
            best_have_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            total_reg <= '0;
            target_reg <= '0;
            tvalid_reg <= 1'b0;
            rev_reg <= 1'b0;
            reach_reg <= wpf_pkg::RESET_REACH;
            loop_reg <= wpf_pkg::RESET_LOOP;
            iss_active_reg <= 1'b0;
            iss_left_reg <= '0;
            iss_dir_reg <= 1'b0;
            rd_vld_reg <= 1'b0;
            best_have_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            target_reg <= target_next;
            tvalid_reg <= tvalid_next;
            rev_reg <= rev_next;
            reach_reg <= reach_next;
            loop_reg <= loop_next;
            iss_active_reg <= iss_active_next;
            iss_left_reg <= iss_left_next;
            iss_dir_reg <= iss_dir_next;
            rd_vld_reg <= rd_vld_next;
            best_have_reg <= best_have_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg <= act_next;
        pos_reg <= pos_next;
        status_reg <= status_next;
        found_reg <= found_next;
        iss_addr_reg <= iss_addr_next;
        rd_idx_reg <= rd_idx_next;
        best_dist_reg <= best_dist_next;
        best_idx_reg <= best_idx_next;
        best_way_reg <= best_way_next;
        rsp_reg <= rsp_next;
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

    `ASSERT_IMPLIES(a_total_bound, clk, rst_n, 1'b1, total_reg <= CNT_MAX)
    `ASSERT_IMPLIES(a_target_in_table, clk, rst_n, tvalid_reg, CNT_BITS'(target_reg) < total_reg)
    `ASSERT_IMPLIES(a_reads_while_busy, clk, rst_n, iss_active_reg,
                    state_reg != S_IDLE && state_reg != S_OUT)
    `ASSERT_IMPLIES(a_rsp_from_out, clk, rst_n, $rose(rsp_valid_reg), $past(state_reg) == S_OUT)

endmodule
